>>> design/rotated_rect_circle_overlap_defines.svh
// Assertion macros for the rotated rectangle against circle overlap block.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef ROTATED_RECT_CIRCLE_OVERLAP_DEFINES_SVH
`define ROTATED_RECT_CIRCLE_OVERLAP_DEFINES_SVH

// same-cycle implication
`define RRCO_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rrco: overlap pipeline check failed");

// next-cycle implication
`define RRCO_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rrco: overlap pipeline check failed");

`endif

>>> design/rrco_pkg.sv
// Shared widths, register codes, stage payload structs and the sine table
// builder for the rotated rectangle against circle overlap block. No dependencies.
package rrco_pkg;

  localparam int TRIG_TABLE_DEPTH = 1024;
  localparam int TRIG_IDX_W       = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int TRIG_MAG_W       = 15;   // 0..16384, Q1.14
  localparam int TRIG_W           = 16;   // signed Q1.14
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int ANGLE_W    = 12;
  localparam int PHASE_W    = 10;
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 15;
  localparam int SCALE_W    = 12;
  localparam int RADIUS_W   = 16;

  localparam int CTR_W      = 18;   // 2*x + w, Q.5
  localparam int DELTA_W    = 19;   // 2*cx - ctr, Q.5
  localparam int PROD_W     = TRIG_W + DELTA_W;
  localparam int LOC_W      = 34;   // rotated point, Q.19
  localparam int BND_W      = 33;   // box edges, Q.19
  localparam int DIST_W     = 34;   // distance outside the box
  localparam int HALF_W     = DIST_W / 2;
  localparam int PP_W       = 2 * HALF_W;
  localparam int SQ_W       = 2 * DIST_W;
  localparam int RPROD_W    = RADIUS_W + SCALE_W;
  localparam int RADQ_W     = 30;   // radius, Q.12, signed
  localparam int RMAG_W     = 29;
  localparam int RSQ_W      = 2 * RMAG_W;
  localparam int RSQ_SHIFT  = 14;   // Q.24 -> Q.38
  localparam int CMP_W      = RSQ_W + RSQ_SHIFT;

  localparam int STAGES     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIRCLE_X         = 3'd0,
    REG_CIRCLE_Y         = 3'd1,
    REG_BASE_RADIUS      = 3'd2,
    REG_DETECT_CONCEALED = 3'd3
  } cfg_reg_e;

  typedef logic [STAGES-1:0] stage_vec_t;

  typedef logic [TRIG_MAG_W-1:0] trig_table_t [TRIG_TABLE_DEPTH+1];

  typedef struct packed {
    logic                      neg_sin;
    logic                      neg_cos;
    logic signed [CTR_W-1:0]   ctrx;
    logic signed [CTR_W-1:0]   ctry;
    logic signed [DELTA_W-1:0] dxp;
    logic signed [DELTA_W-1:0] dyp;
    logic signed [BND_W-1:0]   lox;
    logic signed [BND_W-1:0]   hix;
    logic signed [BND_W-1:0]   loy;
    logic signed [BND_W-1:0]   hiy;
    logic signed [RADQ_W-1:0]  rad;
    logic                      mask;
  } s1_t;

  typedef struct packed {
    logic signed [LOC_W-1:0] lx;
    logic signed [LOC_W-1:0] ly;
    logic signed [BND_W-1:0] lox;
    logic signed [BND_W-1:0] hix;
    logic signed [BND_W-1:0] loy;
    logic signed [BND_W-1:0] hiy;
    logic [RSQ_W-1:0]        msq;
    logic                    mask;
  } s3_t;

  // Quarter-wave sine, Q1.14, by fixed-point Taylor series; elaboration only.
  function automatic trig_table_t trig_table_init();
    trig_table_t       tbl;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   r;
    longint            sum;
    for (int i = 0; i <= TRIG_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / TRIG_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (unsigned'(sum) + 64'd32768) >> 16;
      if (r > 64'd16384) begin
        r = 64'd16384;
      end
      tbl[i] = r[TRIG_MAG_W-1:0];
    end
    return tbl;
  endfunction

endpackage

>>> design/rrco_trig_rom.sv
// Quarter-wave sine ROM with two registered read ports (sine and cosine).
// Depends on rrco_pkg for the table builder and widths.
module rrco_trig_rom (
  input  logic                             clk,
  input  logic                             en,
  input  logic [rrco_pkg::TRIG_IDX_W-1:0]  sin_idx,
  input  logic [rrco_pkg::TRIG_IDX_W-1:0]  cos_idx,
  output logic [rrco_pkg::TRIG_MAG_W-1:0]  sin_mag,
  output logic [rrco_pkg::TRIG_MAG_W-1:0]  cos_mag
);
  import rrco_pkg::*;

  localparam trig_table_t ROM = trig_table_init();

  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag <= ROM[sin_idx];
      cos_mag <= ROM[cos_idx];
    end
  end

endmodule

>>> design/rrco_rotate.sv
// Stages 2 and 3: signed trig, rotation products and sums; radius magnitude
// and square. Depends on rrco_pkg.
module rrco_rotate (
  input  logic                            clk,
  input  rrco_pkg::stage_vec_t            en,
  input  rrco_pkg::s1_t                   s1,
  input  logic [rrco_pkg::TRIG_MAG_W-1:0] sin_mag,
  input  logic [rrco_pkg::TRIG_MAG_W-1:0] cos_mag,
  output rrco_pkg::s3_t                   s3
);
  import rrco_pkg::*;

  logic signed [TRIG_W-1:0]  sn_abs;
  logic signed [TRIG_W-1:0]  cs_abs;
  logic signed [TRIG_W-1:0]  sn;
  logic signed [TRIG_W-1:0]  cs;

  // stage 2 registers
  logic signed [PROD_W-1:0]  p_cx;
  logic signed [PROD_W-1:0]  p_sy;
  logic signed [PROD_W-1:0]  p_cy;
  logic signed [PROD_W-1:0]  p_sx;
  logic signed [CTR_W-1:0]   ctrx2;
  logic signed [CTR_W-1:0]   ctry2;
  logic signed [BND_W-1:0]   lox2;
  logic signed [BND_W-1:0]   hix2;
  logic signed [BND_W-1:0]   loy2;
  logic signed [BND_W-1:0]   hiy2;
  logic [RMAG_W-1:0]         rmag2;
  logic                      mask2;

  always_comb begin
    sn_abs = signed'({1'b0, sin_mag});
    cs_abs = signed'({1'b0, cos_mag});
    sn     = s1.neg_sin ? -sn_abs : sn_abs;
    cs     = s1.neg_cos ? -cs_abs : cs_abs;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_cx  <= PROD_W'(cs) * PROD_W'(s1.dxp);
      p_sy  <= PROD_W'(sn) * PROD_W'(s1.dyp);
      p_cy  <= PROD_W'(cs) * PROD_W'(s1.dyp);
      p_sx  <= PROD_W'(sn) * PROD_W'(s1.dxp);
      ctrx2 <= s1.ctrx;
      ctry2 <= s1.ctry;
      lox2  <= s1.lox;
      hix2  <= s1.hix;
      loy2  <= s1.loy;
      hiy2  <= s1.hiy;
      rmag2 <= RMAG_W'(s1.rad[RADQ_W-1] ? -s1.rad : s1.rad);
      mask2 <= s1.mask;
    end
  end

  // rotate by the negative angle about the box centre, Q.19
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3.lx   <= LOC_W'(p_cx) + LOC_W'(p_sy) + (LOC_W'(ctrx2) <<< 14);
      s3.ly   <= LOC_W'(p_cy) - LOC_W'(p_sx) + (LOC_W'(ctry2) <<< 14);
      s3.lox  <= lox2;
      s3.hix  <= hix2;
      s3.loy  <= loy2;
      s3.hiy  <= hiy2;
      s3.msq  <= RSQ_W'(rmag2) * RSQ_W'(rmag2);
      s3.mask <= mask2;
    end
  end

endmodule

>>> design/rrco_dist.sv
// Stages 4 to 7: distance outside the box, split squares, sum and the
// compare against the squared radius. Depends on rrco_pkg.
module rrco_dist (
  input  logic                 clk,
  input  rrco_pkg::stage_vec_t en,
  input  rrco_pkg::s3_t        s3,
  output logic                 overlaps
);
  import rrco_pkg::*;

  logic signed [BND_W+1:0] lxw;
  logic signed [BND_W+1:0] lyw;
  logic [DIST_W-1:0]       ex_next;
  logic [DIST_W-1:0]       ey_next;

  logic [DIST_W-1:0]       ex;
  logic [DIST_W-1:0]       ey;
  logic [RSQ_W-1:0]        msq4;
  logic                    mask4;

  logic [PP_W-1:0]         hh_x;
  logic [PP_W-1:0]         hl_x;
  logic [PP_W-1:0]         ll_x;
  logic [PP_W-1:0]         hh_y;
  logic [PP_W-1:0]         hl_y;
  logic [PP_W-1:0]         ll_y;
  logic [RSQ_W-1:0]        msq5;
  logic                    mask5;

  logic [SQ_W-1:0]         sqx;
  logic [SQ_W-1:0]         sqy;
  logic [RSQ_W-1:0]        msq6;
  logic                    mask6;

  logic [SQ_W-1:0]         dsq;
  logic [CMP_W-1:0]        rsq;

  always_comb begin
    lxw = (BND_W+2)'(s3.lx);
    lyw = (BND_W+2)'(s3.ly);
    if (lxw > (BND_W+2)'(s3.hix)) begin
      ex_next = DIST_W'(lxw - (BND_W+2)'(s3.hix));
    end else if (lxw < (BND_W+2)'(s3.lox)) begin
      ex_next = DIST_W'((BND_W+2)'(s3.lox) - lxw);
    end else begin
      ex_next = '0;
    end
    if (lyw > (BND_W+2)'(s3.hiy)) begin
      ey_next = DIST_W'(lyw - (BND_W+2)'(s3.hiy));
    end else if (lyw < (BND_W+2)'(s3.loy)) begin
      ey_next = DIST_W'((BND_W+2)'(s3.loy) - lyw);
    end else begin
      ey_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ex    <= ex_next;
      ey    <= ey_next;
      msq4  <= s3.msq;
      mask4 <= s3.mask;
    end
  end

  // squares as three half-width partial products each
  always_ff @(posedge clk) begin
    if (en[4]) begin
      hh_x  <= PP_W'(ex[DIST_W-1:HALF_W]) * PP_W'(ex[DIST_W-1:HALF_W]);
      hl_x  <= PP_W'(ex[DIST_W-1:HALF_W]) * PP_W'(ex[HALF_W-1:0]);
      ll_x  <= PP_W'(ex[HALF_W-1:0]) * PP_W'(ex[HALF_W-1:0]);
      hh_y  <= PP_W'(ey[DIST_W-1:HALF_W]) * PP_W'(ey[DIST_W-1:HALF_W]);
      hl_y  <= PP_W'(ey[DIST_W-1:HALF_W]) * PP_W'(ey[HALF_W-1:0]);
      ll_y  <= PP_W'(ey[HALF_W-1:0]) * PP_W'(ey[HALF_W-1:0]);
      msq5  <= msq4;
      mask5 <= mask4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sqx   <= (SQ_W'(hh_x) << (2 * HALF_W)) + (SQ_W'(hl_x) << (HALF_W + 1)) + SQ_W'(ll_x);
      sqy   <= (SQ_W'(hh_y) << (2 * HALF_W)) + (SQ_W'(hl_y) << (HALF_W + 1)) + SQ_W'(ll_y);
      msq6  <= msq5;
      mask6 <= mask5;
    end
  end

  always_comb begin
    dsq = sqx + sqy;
    rsq = {msq6, RSQ_SHIFT'(0)};
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      overlaps <= !mask6 && (CMP_W'(dsq) <= rsq);
    end
  end

endmodule

>>> design/rotated_rect_circle_overlap.sv
// Top level of the rotated rectangle against circle overlap test: config
// registers, handshake and stage 1. Depends on rrco_pkg, rrco_trig_rom,
// rrco_rotate, rrco_dist and the assertion macro header.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes circle_x,
//   circle_y, base_radius and detect_concealed; cfg_ready is always high and
//   unknown indexes are ignored. Write only while no beat is in flight.
//   Box channel (box_valid/box_stall) carries one rectangle per beat; the
//   result channel (res_valid/res_stall) returns one overlaps bit per beat,
//   in order.
//   Throughput is one beat per cycle while box_stall is low, through the
//   seven-stage pipeline: sine ROM read, rotation multipliers, rotation
//   sums, clamp, split squares, square assembly, sum and compare.
//   Reset empties the pipeline and clears all config registers to zero.
//   When res_stall is high the pipeline keeps moving into empty stages;
//   box_stall rises only once all seven stages hold a beat.
`include "rotated_rect_circle_overlap_defines.svh"

module rotated_rect_circle_overlap (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rrco_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rrco_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  box_valid,
  output logic                                  box_stall,
  input  logic signed [rrco_pkg::COORD_W-1:0]   box_x,
  input  logic signed [rrco_pkg::COORD_W-1:0]   box_y,
  input  logic [rrco_pkg::SIZE_W-1:0]           box_width,
  input  logic [rrco_pkg::SIZE_W-1:0]           box_height,
  input  logic [rrco_pkg::ANGLE_W-1:0]          box_angle,
  input  logic                                  target_concealed,
  input  logic                                  extra_detect,
  input  logic [rrco_pkg::SCALE_W-1:0]          radius_scale,
  input  logic signed [rrco_pkg::COORD_W-1:0]   radius_offset,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic                                  overlaps
);
  import rrco_pkg::*;

  logic signed [COORD_W-1:0] circle_x;
  logic signed [COORD_W-1:0] circle_y;
  logic [RADIUS_W-1:0]       base_radius;
  logic                      detect_concealed;

  stage_vec_t valid;
  stage_vec_t valid_next;
  stage_vec_t en;

  logic [1:0]                      quad;
  logic [PHASE_W+TRIG_IDX_W-1:0]   phase_prod;
  logic [TRIG_IDX_W-1:0]           idx_base;
  logic [TRIG_IDX_W-1:0]           idx_mirror;
  logic [TRIG_IDX_W-1:0]           sin_idx;
  logic [TRIG_IDX_W-1:0]           cos_idx;
  logic signed [CTR_W-1:0]         right_x;
  logic signed [CTR_W-1:0]         bottom_y;
  logic [RPROD_W-1:0]              rad_prod;
  s1_t                             s1_next;
  s1_t                             s1;

  logic [TRIG_MAG_W-1:0] sin_mag;
  logic [TRIG_MAG_W-1:0] cos_mag;
  s3_t                   s3;

  int occ;
  int occ_expect;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_x         <= '0;
      circle_y         <= '0;
      base_radius      <= '0;
      detect_concealed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CIRCLE_X:         circle_x         <= signed'(cfg_data);
        REG_CIRCLE_Y:         circle_y         <= signed'(cfg_data);
        REG_BASE_RADIUS:      base_radius      <= cfg_data;
        REG_DETECT_CONCEALED: detect_concealed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its successor loads
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || !res_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
    for (int k = 0; k < STAGES; k++) begin
      if (en[k]) begin
        valid_next[k] = (k == 0) ? box_valid : valid[(k == 0) ? 0 : k - 1];
      end else begin
        valid_next[k] = valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign box_stall = !en[0];
  assign res_valid = valid[STAGES-1];

  // stage 1: table address, box centre, offsets, edges and radius
  always_comb begin
    quad       = box_angle[ANGLE_W-1:PHASE_W];
    phase_prod = (PHASE_W+TRIG_IDX_W)'(box_angle[PHASE_W-1:0])
               * (PHASE_W+TRIG_IDX_W)'(TRIG_TABLE_DEPTH);
    idx_base   = phase_prod[PHASE_W+TRIG_IDX_W-1:PHASE_W];
    idx_mirror = TRIG_IDX_W'(TRIG_TABLE_DEPTH) - idx_base;
    sin_idx    = quad[0] ? idx_mirror : idx_base;
    cos_idx    = quad[0] ? idx_base : idx_mirror;

    right_x    = CTR_W'(box_x) + CTR_W'({1'b0, box_width});
    bottom_y   = CTR_W'(box_y) + CTR_W'({1'b0, box_height});
    rad_prod   = RPROD_W'(base_radius) * RPROD_W'(radius_scale);

    s1_next.neg_sin = quad[1];
    s1_next.neg_cos = quad[1] ^ quad[0];
    s1_next.ctrx    = (CTR_W'(box_x) <<< 1) + CTR_W'({1'b0, box_width});
    s1_next.ctry    = (CTR_W'(box_y) <<< 1) + CTR_W'({1'b0, box_height});
    s1_next.dxp     = (DELTA_W'(circle_x) <<< 1) - DELTA_W'(s1_next.ctrx);
    s1_next.dyp     = (DELTA_W'(circle_y) <<< 1) - DELTA_W'(s1_next.ctry);
    s1_next.lox     = BND_W'(box_x) <<< 15;
    s1_next.hix     = BND_W'(right_x) <<< 15;
    s1_next.loy     = BND_W'(box_y) <<< 15;
    s1_next.hiy     = BND_W'(bottom_y) <<< 15;
    s1_next.rad     = signed'(RADQ_W'(rad_prod)) + (RADQ_W'(radius_offset) <<< 8);
    s1_next.mask    = target_concealed && !(detect_concealed || extra_detect);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= s1_next;
    end
  end

  rrco_trig_rom u_trig_rom (
    .clk     (clk),
    .en      (en[0]),
    .sin_idx (sin_idx),
    .cos_idx (cos_idx),
    .sin_mag (sin_mag),
    .cos_mag (cos_mag)
  );

  rrco_rotate u_rotate (
    .clk     (clk),
    .en      (en),
    .s1      (s1),
    .sin_mag (sin_mag),
    .cos_mag (cos_mag),
    .s3      (s3)
  );

  rrco_dist u_dist (
    .clk      (clk),
    .en       (en),
    .s3       (s3),
    .overlaps (overlaps)
  );

  assign occ        = $countones(valid);
  assign occ_expect = occ + int'(box_valid && !box_stall) - int'(res_valid && !res_stall);

  `RRCO_ASSERT_IMP(a_stall_only_when_full, clk, rst, box_stall, (&valid) && res_stall)

  `RRCO_ASSERT_NXT(a_occupancy_tracks_beats, clk, rst, 1'b1, occ == $past(occ_expect))

  `RRCO_ASSERT_IMP(a_result_leaves_on_beat, clk, rst, !$past(rst) && $fell(res_valid), $past(!res_stall))

endmodule

>>> tb/tb.sv
// Self-checking bench for rotated_rect_circle_overlap: random and directed box beats
// are checked against an in-bench overlap predictor under random stalls and gaps.
// Depends on rrco_pkg and the design sources.
module tb;
  import rrco_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic [ANGLE_W-1:0]        ang;
    logic                      conc;
    logic                      extra;
    logic [SCALE_W-1:0]        scale;
    logic signed [COORD_W-1:0] offs;
  } box_beat_t;

  localparam u64_t QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int   FIRST_SPARE_REG  = 4;
  localparam int   PIPE_DEPTH       = 7;
  localparam int   N_RAND_PHASES    = 8;
  localparam int   PHASE_BEATS      = 65;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic box_valid = 1'b0;
  logic box_stall;
  logic signed [COORD_W-1:0] box_x;
  logic signed [COORD_W-1:0] box_y;
  logic [SIZE_W-1:0] box_width;
  logic [SIZE_W-1:0] box_height;
  logic [ANGLE_W-1:0] box_angle;
  logic target_concealed;
  logic extra_detect;
  logic [SCALE_W-1:0] radius_scale;
  logic signed [COORD_W-1:0] radius_offset;
  logic res_valid;
  logic res_stall = 1'b0;
  logic overlaps;

  box_beat_t box_cur = '{default: '0};
  box_beat_t box_queue[$];
  bit overlap_expect[$];
  int gap_left = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  bit calm = 1'b0;

  logic signed [COORD_W-1:0] circ_x = '0;
  logic signed [COORD_W-1:0] circ_y = '0;
  logic [RADIUS_W-1:0] circ_rad = '0;
  logic det_conc = 1'b0;
  logic [TRIG_MAG_W-1:0] sine_lut [0:TRIG_TABLE_DEPTH];

  assign box_x            = box_cur.x;
  assign box_y            = box_cur.y;
  assign box_width        = box_cur.w;
  assign box_height       = box_cur.h;
  assign box_angle        = box_cur.ang;
  assign target_concealed = box_cur.conc;
  assign extra_detect     = box_cur.extra;
  assign radius_scale     = box_cur.scale;
  assign radius_offset    = box_cur.offs;

  rotated_rect_circle_overlap uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [TRIG_MAG_W-1:0] quarter_wave(int idx);
    u64_t x, x2, term, r;
    longint sum;
    x = (QUARTER_TURN_Q30 * u64_t'(idx)) / u64_t'(TRIG_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (u64_t'(sum) + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return r[TRIG_MAG_W-1:0];
  endfunction

  function automatic longint sine_of(logic [ANGLE_W-1:0] a);
    int idx;
    longint v;
    idx = int'(a[PHASE_W-1:0]) * TRIG_TABLE_DEPTH / 1024;
    if (a[PHASE_W]) idx = TRIG_TABLE_DEPTH - idx;
    v = longint'(sine_lut[idx]);
    return a[PHASE_W+1] ? -v : v;
  endfunction

  // circle centre rotated into the box frame, clamped, distance against radius
  function automatic bit circle_touches_box(box_beat_t b);
    longint sn, cs, ctrx, ctry, dxp, dyp, lx, ly, qx, qy, lo, hi, rad;
    u64_t ex, ey, rm;
    logic [127:0] dsq, rsq;
    if (b.conc && !(det_conc || b.extra)) return 1'b0;
    sn = sine_of(b.ang);
    cs = sine_of(b.ang + 12'd1024);
    ctrx = 2 * longint'(b.x) + longint'(b.w);
    ctry = 2 * longint'(b.y) + longint'(b.h);
    dxp = 2 * longint'(circ_x) - ctrx;
    dyp = 2 * longint'(circ_y) - ctry;
    lx = cs * dxp + sn * dyp + ctrx * 16384;
    ly = cs * dyp - sn * dxp + ctry * 16384;
    lo = longint'(b.x) * 32768;
    hi = (longint'(b.x) + longint'(b.w)) * 32768;
    qx = (lx > hi) ? hi : lx;
    qx = (qx < lo) ? lo : qx;
    lo = longint'(b.y) * 32768;
    hi = (longint'(b.y) + longint'(b.h)) * 32768;
    qy = (ly > hi) ? hi : ly;
    qy = (qy < lo) ? lo : qy;
    ex = u64_t'((lx - qx < 0) ? qx - lx : lx - qx);
    ey = u64_t'((ly - qy < 0) ? qy - ly : ly - qy);
    dsq = 128'(ex) * 128'(ex) + 128'(ey) * 128'(ey);
    rad = (longint'(circ_rad) * longint'(b.scale) + longint'(b.offs) * 256) * 128;
    rm = u64_t'((rad < 0) ? -rad : rad);
    rsq = 128'(rm) * 128'(rm);
    return dsq <= rsq;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(24, 6);
  endfunction

  function automatic box_beat_t box_of(int x, int y, int w, int h, int ang,
                                       bit conc, bit extra, int scale, int offs);
    box_beat_t b;
    b.x = COORD_W'(x);
    b.y = COORD_W'(y);
    b.w = SIZE_W'(w);
    b.h = SIZE_W'(h);
    b.ang = ANGLE_W'(ang);
    b.conc = conc;
    b.extra = extra;
    b.scale = SCALE_W'(scale);
    b.offs = COORD_W'(offs);
    return b;
  endfunction

  // near beats land around the circle so both answers stay common
  function automatic box_beat_t random_box(bit near);
    bit conc;
    conc = ($urandom_range(3) == 0);
    if (near) begin
      return box_of(int'(circ_x) - int'($urandom_range(6000)),
                     int'(circ_y) - int'($urandom_range(6000)),
                     $urandom_range(6000), $urandom_range(6000), $urandom,
                     conc, $urandom_range(1), $urandom_range(600),
                     int'($urandom_range(4000)) - 2000);
    end
    return box_of($urandom, $urandom, $urandom, $urandom, $urandom,
                  conc, $urandom_range(1), $urandom, $urandom);
  endfunction

  always @(posedge clk) begin : drive
    if (rst) begin
      box_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (box_valid && !box_stall) overlap_expect.push_back(circle_touches_box(box_cur));
      if (!box_valid || !box_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          box_valid <= 1'b0;
        end else if (box_queue.size() > 0) begin
          box_cur <= box_queue.pop_front();
          box_valid <= 1'b1;
          gap_left <= idle_len();
        end else begin
          box_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check
    bit want;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (overlap_expect.size() == 0) begin
          $error("overlaps: no beat expected, got %0b", overlaps);
          mismatch_count++;
        end else begin
          want = overlap_expect.pop_front();
          if (overlaps !== want) begin
            $error("overlaps: expected %0b, got %0b", want, overlaps);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(99) < 35) begin
        res_stall <= 1'b1;
        stall_left <= idle_len() + 1;
      end else begin
        res_stall <= 1'b0;
        stall_left <= idle_len();
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CIRCLE_X:         circ_x = data;
      REG_CIRCLE_Y:         circ_y = data;
      REG_BASE_RADIUS:      circ_rad = data;
      REG_DETECT_CONCEALED: det_conc = data[0];
      default: ;
    endcase
  endtask

  task automatic set_circle(int cx, int cy, int rad, bit det);
    write_reg(REG_CIRCLE_X, CFG_DATA_W'(cx));
    write_reg(REG_CIRCLE_Y, CFG_DATA_W'(cy));
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, FIRST_SPARE_REG)),
              CFG_DATA_W'($urandom));
    write_reg(REG_BASE_RADIUS, CFG_DATA_W'(rad));
    write_reg(REG_DETECT_CONCEALED, CFG_DATA_W'(det));
  endtask

  task automatic drain();
    while (box_queue.size() > 0 || box_valid || overlap_expect.size() > 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  initial begin : stimulus
    for (int i = 0; i <= TRIG_TABLE_DEPTH; i++) sine_lut[i] = quarter_wave(i);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset values of the circle registers
    for (int i = 0; i < 10; i++) box_queue.push_back(random_box($urandom_range(1)));
    drain();

    // circle at (100, 50), radius 20; box right edge at 80 so it just touches
    set_circle(1600, 800, 320, 1'b0);
    box_queue.push_back(box_of(0, 0, 1280, 1600, 0, 0, 0, 256, 0));
    box_queue.push_back(box_of(0, 0, 1280, 1600, 0, 0, 0, 256, -1));
    box_queue.push_back(box_of(0, 0, 1280, 1600, 0, 0, 0, 0, -320));
    box_queue.push_back(box_of(0, 0, 1280, 1600, 0, 0, 0, 0, -319));
    box_queue.push_back(box_of(0, 0, 3200, 1600, 0, 0, 0, 0, 0));
    box_queue.push_back(box_of(1600, 800, 0, 0, 0, 0, 0, 0, 0));
    box_queue.push_back(box_of(1600, 0, 0, 0, 0, 0, 0, 0, 0));
    box_queue.push_back(box_of(1600, 0, 0, 0, 0, 0, 0, 256, 0));
    box_queue.push_back(box_of(0, 0, 3200, 1600, 0, 1, 0, 256, 0));
    box_queue.push_back(box_of(0, 0, 3200, 1600, 0, 1, 1, 256, 0));
    box_queue.push_back(box_of(-32768, -32768, 32767, 32767, 4095, 0, 1, 4095, 32767));
    box_queue.push_back(box_of(32767, 32767, 32767, 32767, 0, 0, 0, 0, -32768));
    box_queue.push_back(box_of(-32768, 32767, 0, 32767, 2048, 1, 1, 4095, -32768));
    foreach (box_queue[i]) ;
    for (int a = 0; a < 4096; a += 512)
      box_queue.push_back(box_of(0, 0, 1280, 1600, a, 0, 0, 256, 0));
    box_queue.push_back(box_of(0, 0, 1280, 1600, 1, 0, 0, 256, 0));
    box_queue.push_back(box_of(0, 0, 1280, 1600, 4095, 0, 0, 256, 0));
    drain();

    for (int p = 0; p < N_RAND_PHASES; p++) begin
      calm = (p == 2 || p == 5);
      case (p)
        0: set_circle(-32768, 32767, 65535, 1'b1);
        1: set_circle(32767, -32768, 0, 1'b0);
        2: set_circle(0, 0, $urandom_range(4000), 1'b1);
        default: set_circle($urandom, $urandom,
                            ($urandom_range(3) == 0) ? $urandom : $urandom_range(4000),
                            $urandom_range(1));
      endcase
      for (int i = 0; i < PHASE_BEATS; i++)
        box_queue.push_back(random_box($urandom_range(99) < 65));
      drain();
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/rrco_pkg.sv
design/rrco_trig_rom.sv
design/rrco_rotate.sv
design/rrco_dist.sv
design/rotated_rect_circle_overlap.sv
tb/tb.sv
